// ===== rtl/sqra_pkg.sv =====
`default_nettype none
package sqra_pkg;

  localparam int LANES    = 8;
  localparam int CNT_W    = 24;
  localparam int DIV_W    = 56;
  localparam logic [CNT_W-1:0] CNT_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    OP_OBS,
    OP_LD_COEF,
    OP_LD_MEAN,
    OP_LD_INV
  } sqra_op_t;

  typedef enum logic [2:0] {
    CFG_BURN,
    CFG_GAMMA,
    CFG_ALPHA,
    CFG_TAU,
    CFG_STD
  } sqra_cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_Z_MUL,
    S_Z_WB,
    S_D_MUL,
    S_D_ACC,
    S_GRAD,
    S_NORM,
    S_LG_MUL,
    S_LG_WB,
    S_T_MUL,
    S_T_WB,
    S_P_CHK,
    S_P_MUL,
    S_P_WB,
    S_LR_MUL,
    S_LR_WB,
    S_S_MUL,
    S_S_WB,
    S_U_MUL,
    S_U_WB,
    S_A_MUL,
    S_A_WB,
    S_A_DIV,
    S_FIN
  } sqra_state_t;

  // 2^(-2^-(i+1)) in Q0.32
  function automatic logic [31:0] tab_f(input logic [3:0] i);
    logic [31:0] v;
    unique case (i)
      4'd0:  v = 32'd3037000500;
      4'd1:  v = 32'd3611622603;
      4'd2:  v = 32'd3938502376;
      4'd3:  v = 32'd4112874773;
      4'd4:  v = 32'd4202935003;
      4'd5:  v = 32'd4248701965;
      4'd6:  v = 32'd4271771996;
      4'd7:  v = 32'd4283353945;
      4'd8:  v = 32'd4289156690;
      4'd9:  v = 32'd4292061009;
      4'd10: v = 32'd4293513907;
      4'd11: v = 32'd4294240540;
      4'd12: v = 32'd4294603903;
      4'd13: v = 32'd4294785595;
      4'd14: v = 32'd4294876445;
      4'd15: v = 32'd4294921870;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sqra_mul.sv =====
`default_nettype none
module sqra_mul (
  input  wire                clk,
  input  wire signed [32:0]  a,
  input  wire signed [32:0]  b,
  output logic signed [65:0] p
);
  logic signed [65:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;
endmodule
`default_nettype wire

// ===== rtl/sqra_div.sv =====
`default_nettype none
module sqra_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire signed [sqra_pkg::DIV_W:0] num,
  input  wire [sqra_pkg::CNT_W-1:0]    den,
  output logic                         busy,
  output logic                         done,
  output logic signed [31:0]           quo
);
  import sqra_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy_r, done_r, neg_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W:0]    rem_r;
  logic [DIV_W-1:0]  q_r;
  logic [CNT_W-1:0]  den_r;
  logic [DIV_W:0]    mag;
  logic [CNT_W:0]    sh;
  logic              fits;

  assign mag  = num[DIV_W] ? (DIV_W+1)'(-num) : (DIV_W+1)'(num);
  assign sh   = {rem_r[CNT_W-1:0], q_r[DIV_W-1]};
  assign fits = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  // restoring, one quotient bit a cycle on the magnitude
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[DIV_W];
      q_r   <= mag[DIV_W-1:0];
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? sh - {1'b0, den_r} : sh;
      q_r   <= {q_r[DIV_W-2:0], fits};
    end
  end

  always_comb begin
    if (!neg_r) begin
      quo = (q_r > DIV_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(q_r[31:0]);
    end else begin
      quo = (q_r > DIV_W'(33'h080000000)) ? 32'sh80000000 : -$signed(q_r[31:0]);
    end
  end

  assign busy = busy_r;
  assign done = done_r;
endmodule
`default_nettype wire

// ===== rtl/sgd_quantile_regression_averaged_unit.sv =====
`default_nettype none
// Load items: the write is made in S_LOAD and the result is registered from S_FIN.
// Observations: z (when standardizing), dot, gradient, normalize, log2, power, learning
//   rate and step, coefficient update, and the per-feature divide when averaging.
// One item in flight; the shared 33x33 multiplier and the 56-step divider set the rate.
// Reset: synchronous, active low; coefficients, averages, means and count clear,
//   inverse scales load 1.0, registers take their defaults. No clearing pass.
module sgd_quantile_regression_averaged_unit #(
  parameter int FEATURES = 8
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [2:0]          cfg_index,
  input  wire [24:0]         cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire [1:0]          in_operation,
  input  wire [2:0]          in_index,
  input  wire signed [31:0]  in_load_value,
  input  wire signed [31:0]  in_x_0,
  input  wire signed [31:0]  in_x_1,
  input  wire signed [31:0]  in_x_2,
  input  wire signed [31:0]  in_x_3,
  input  wire signed [31:0]  in_x_4,
  input  wire signed [31:0]  in_x_5,
  input  wire signed [31:0]  in_x_6,
  input  wire signed [31:0]  in_x_7,
  input  wire signed [31:0]  in_response,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_avg_0,
  output logic signed [31:0] out_avg_1,
  output logic signed [31:0] out_avg_2,
  output logic signed [31:0] out_avg_3,
  output logic signed [31:0] out_avg_4,
  output logic signed [31:0] out_avg_5,
  output logic signed [31:0] out_avg_6,
  output logic signed [31:0] out_avg_7,
  output logic [23:0]        out_observations_seen,
  output logic               out_averaging_active
);
  import sqra_pkg::*;

  localparam logic [2:0] JLAST = 3'(FEATURES - 1);

  // config
  logic [23:0] burn_r;
  logic [24:0] gamma_r;
  logic [16:0] alpha_r, tau_r;
  logic        std_r;

  // architectural state
  logic signed [31:0] coef_r [LANES];
  logic signed [31:0] coef_nxt [LANES];
  logic signed [31:0] avg_r [LANES];
  logic signed [31:0] avg_nxt [LANES];
  logic signed [31:0] mean_r [LANES];
  logic signed [31:0] mean_nxt [LANES];
  logic signed [31:0] inv_r [LANES];
  logic signed [31:0] inv_nxt [LANES];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // sequencer
  sqra_state_t state_r, state_nxt;
  logic [2:0]  j_r, j_nxt;
  logic [3:0]  i_r, i_nxt;

  // captured item
  sqra_op_t           op_r;
  logic [2:0]         idx_r;
  logic signed [31:0] lv_r, y_r;
  logic signed [31:0] x_in [LANES];
  logic signed [31:0] x_r [LANES];

  // working values
  logic signed [31:0] z_r [LANES];
  logic signed [31:0] z_nxt [LANES];
  logic signed [51:0] acc_r, acc_nxt;
  logic signed [17:0] g_r, g_nxt;
  logic [30:0]        lg_y_r, lg_y_nxt;
  logic [4:0]         lg_e_r, lg_e_nxt;
  logic [15:0]        frac_r, frac_nxt;
  logic [20:0]        t_r, t_nxt;
  logic [31:0]        m_r, m_nxt;
  logic               m_one_r, m_one_nxt;
  logic [24:0]        lr_r, lr_nxt;
  logic signed [31:0] s_r, s_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_avg_r [LANES];
  logic signed [31:0] out_avg_nxt [LANES];
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic               out_act_r, out_act_nxt;

  // shared units
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic               div_start, div_busy, div_done;
  logic signed [31:0] div_q;
  logic signed [DIV_W:0] div_num;

  logic               in_acc;
  logic [16:0]        alpha_cl, tau_cl;
  logic [CNT_W-1:0]   cnt_inc, mavg, mavg_m1;
  logic [32:0]        pw_full;
  logic [16:0]        pw;
  logic [32:0]        yy;
  logic               avg_on;

  sqra_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  sqra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (mavg),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  assign x_in[0] = in_x_0;
  assign x_in[1] = in_x_1;
  assign x_in[2] = in_x_2;
  assign x_in[3] = in_x_3;
  assign x_in[4] = in_x_4;
  assign x_in[5] = in_x_5;
  assign x_in[6] = in_x_6;
  assign x_in[7] = in_x_7;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign alpha_cl = (alpha_r > 17'd65536) ? 17'd65536 : alpha_r;
  assign tau_cl   = (tau_r > 17'd65536) ? 17'd65536 : tau_r;
  assign cnt_inc  = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  assign avg_on   = cnt_r > burn_r;
  assign mavg     = cnt_r - burn_r;
  assign mavg_m1  = mavg - 1'b1;

  // 2^-frac(t) in Q.32, then the integer part of t as a right shift
  assign pw_full = {m_one_r, m_one_r ? 32'd0 : m_r} >> (6'd16 + 6'(t_r[20:16]));
  assign pw      = pw_full[16:0];
  assign yy      = mul_p[62:30];
  assign div_num = (DIV_W+1)'(mul_p) + (DIV_W+1)'(coef_r[j_r]);

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    cnt_nxt       = cnt_r;
    coef_nxt      = coef_r;
    avg_nxt       = avg_r;
    mean_nxt      = mean_r;
    inv_nxt       = inv_r;
    z_nxt         = z_r;
    acc_nxt       = acc_r;
    g_nxt         = g_r;
    lg_y_nxt      = lg_y_r;
    lg_e_nxt      = lg_e_r;
    frac_nxt      = frac_r;
    t_nxt         = t_r;
    m_nxt         = m_r;
    m_one_nxt     = m_one_r;
    lr_nxt        = lr_r;
    s_nxt         = s_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_avg_nxt   = out_avg_r;
    out_cnt_nxt   = out_cnt_r;
    out_act_nxt   = out_act_r;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (sqra_op_t'(in_operation) == OP_OBS) begin
            cnt_nxt   = cnt_inc;
            lg_y_nxt  = {cnt_inc, 7'd0};
            lg_e_nxt  = 5'd23;
            frac_nxt  = '0;
            acc_nxt   = '0;
            m_one_nxt = 1'b1;
            j_nxt     = '0;
            state_nxt = S_Z_MUL;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end

      S_LOAD: begin
        if ({1'b0, idx_r} < 4'(FEATURES)) begin
          unique case (op_r)
            OP_LD_COEF: begin
              coef_nxt[idx_r] = lv_r;
              for (int k = 0; k < LANES; k++) avg_nxt[k] = '0;
              cnt_nxt = '0;
            end
            OP_LD_MEAN: mean_nxt[idx_r] = lv_r;
            OP_LD_INV:  inv_nxt[idx_r]  = lv_r;
            default: ;
          endcase
        end
        state_nxt = S_FIN;
      end

      S_Z_MUL: begin
        if (std_r) begin
          mul_a     = 33'(sat32(66'(x_r[j_r]) - 66'(mean_r[j_r])));
          mul_b     = 33'(inv_r[j_r]);
          state_nxt = S_Z_WB;
        end else begin
          z_nxt[j_r] = x_r[j_r];
          j_nxt      = (j_r == JLAST) ? 3'd0 : j_r + 1'b1;
          state_nxt  = (j_r == JLAST) ? S_D_MUL : S_Z_MUL;
        end
      end

      S_Z_WB: begin
        z_nxt[j_r] = sat32(mul_p >>> 16);
        j_nxt      = (j_r == JLAST) ? 3'd0 : j_r + 1'b1;
        state_nxt  = (j_r == JLAST) ? S_D_MUL : S_Z_MUL;
      end

      S_D_MUL: begin
        mul_a     = 33'(z_r[j_r]);
        mul_b     = 33'(coef_r[j_r]);
        state_nxt = S_D_ACC;
      end

      S_D_ACC: begin
        acc_nxt   = acc_r + 52'(mul_p >>> 16);
        j_nxt     = (j_r == JLAST) ? 3'd0 : j_r + 1'b1;
        state_nxt = (j_r == JLAST) ? S_GRAD : S_D_MUL;
      end

      S_GRAD: begin
        g_nxt     = ((52'(y_r) < acc_r) ? 18'sd65536 : 18'sd0) - $signed({1'b0, tau_cl});
        state_nxt = S_NORM;
      end

      // bring the count's MSB to bit 30, one place a cycle
      S_NORM: begin
        if (lg_y_r[30]) begin
          i_nxt     = '0;
          state_nxt = S_LG_MUL;
        end else begin
          lg_y_nxt = {lg_y_r[29:0], 1'b0};
          lg_e_nxt = lg_e_r - 1'b1;
        end
      end

      S_LG_MUL: begin
        mul_a     = 33'(lg_y_r);
        mul_b     = 33'(lg_y_r);
        state_nxt = S_LG_WB;
      end

      S_LG_WB: begin
        lg_y_nxt  = yy[31] ? yy[31:1] : yy[30:0];
        frac_nxt  = {frac_r[14:0], yy[31]};
        i_nxt     = i_r + 1'b1;
        state_nxt = (i_r == 4'd15) ? S_T_MUL : S_LG_MUL;
      end

      S_T_MUL: begin
        mul_a     = 33'(alpha_cl);
        mul_b     = 33'({lg_e_r, frac_r});
        state_nxt = S_T_WB;
      end

      S_T_WB: begin
        t_nxt     = mul_p[36:16];
        i_nxt     = '0;
        state_nxt = S_P_CHK;
      end

      S_P_CHK: begin
        if (t_r[4'd15 - i_r] && !m_one_r) begin
          state_nxt = S_P_MUL;
        end else begin
          if (t_r[4'd15 - i_r]) begin
            // first factor times 1.0 is the table entry itself
            m_nxt     = tab_f(i_r);
            m_one_nxt = 1'b0;
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = (i_r == 4'd15) ? S_LR_MUL : S_P_CHK;
        end
      end

      S_P_MUL: begin
        mul_a     = 33'(m_r);
        mul_b     = 33'(tab_f(i_r));
        state_nxt = S_P_WB;
      end

      S_P_WB: begin
        m_nxt     = mul_p[63:32];
        i_nxt     = i_r + 1'b1;
        state_nxt = (i_r == 4'd15) ? S_LR_MUL : S_P_CHK;
      end

      S_LR_MUL: begin
        mul_a     = 33'(gamma_r);
        mul_b     = 33'(pw);
        state_nxt = S_LR_WB;
      end

      S_LR_WB: begin
        lr_nxt    = mul_p[40:16];
        state_nxt = S_S_MUL;
      end

      S_S_MUL: begin
        mul_a     = 33'(lr_r);
        mul_b     = 33'(g_r);
        state_nxt = S_S_WB;
      end

      S_S_WB: begin
        s_nxt     = sat32(mul_p >>> 16);
        j_nxt     = '0;
        state_nxt = S_U_MUL;
      end

      S_U_MUL: begin
        mul_a     = 33'(s_r);
        mul_b     = 33'(z_r[j_r]);
        state_nxt = S_U_WB;
      end

      S_U_WB: begin
        coef_nxt[j_r] = sat32(66'(coef_r[j_r]) - (mul_p >>> 16));
        j_nxt         = (j_r == JLAST) ? 3'd0 : j_r + 1'b1;
        if (j_r == JLAST) begin
          state_nxt = avg_on ? S_A_MUL : S_FIN;
        end else begin
          state_nxt = S_U_MUL;
        end
      end

      // avg = (avg*(m-1) + b) / m
      S_A_MUL: begin
        mul_a     = 33'(avg_r[j_r]);
        mul_b     = 33'(mavg_m1);
        state_nxt = S_A_WB;
      end

      S_A_WB: begin
        div_start = 1'b1;
        state_nxt = S_A_DIV;
      end

      S_A_DIV: begin
        if (div_done) begin
          avg_nxt[j_r] = div_q;
          j_nxt        = (j_r == JLAST) ? 3'd0 : j_r + 1'b1;
          state_nxt    = (j_r == JLAST) ? S_FIN : S_A_MUL;
        end
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_cnt_nxt   = cnt_r;
          out_act_nxt   = avg_on;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      i_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < LANES; k++) begin
        coef_r[k] <= '0;
        avg_r[k]  <= '0;
        mean_r[k] <= '0;
        inv_r[k]  <= 32'sd65536;
      end
      burn_r  <= '0;
      gamma_r <= 25'd65536;
      alpha_r <= 17'd32833;
      tau_r   <= 17'd32768;
      std_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      i_r         <= i_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      coef_r      <= coef_nxt;
      avg_r       <= avg_nxt;
      mean_r      <= mean_nxt;
      inv_r       <= inv_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BURN:  burn_r  <= cfg_data[23:0];
          CFG_GAMMA: gamma_r <= cfg_data;
          CFG_ALPHA: alpha_r <= cfg_data[16:0];
          CFG_TAU:   tau_r   <= cfg_data[16:0];
          CFG_STD:   std_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= sqra_op_t'(in_operation);
      idx_r <= in_index;
      lv_r  <= in_load_value;
      y_r   <= in_response;
      x_r   <= x_in;
    end
    z_r       <= z_nxt;
    acc_r     <= acc_nxt;
    g_r       <= g_nxt;
    lg_y_r    <= lg_y_nxt;
    lg_e_r    <= lg_e_nxt;
    frac_r    <= frac_nxt;
    t_r       <= t_nxt;
    m_r       <= m_nxt;
    m_one_r   <= m_one_nxt;
    lr_r      <= lr_nxt;
    s_r       <= s_nxt;
    out_avg_r <= out_avg_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_act_r <= out_act_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_avg_0             = out_avg_r[0];
  assign out_avg_1             = out_avg_r[1];
  assign out_avg_2             = out_avg_r[2];
  assign out_avg_3             = out_avg_r[3];
  assign out_avg_4             = out_avg_r[4];
  assign out_avg_5             = out_avg_r[5];
  assign out_avg_6             = out_avg_r[6];
  assign out_avg_7             = out_avg_r[7];
  assign out_observations_seen = out_cnt_r;
  assign out_averaging_active  = out_act_r;

`ifndef SYNTH
  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted beat did not start work");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && out_stall) |=> state_r == S_FIN)
    else $error("result overwritten while previous beat pending");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_act_r || out_cnt_r != '0))
    else $error("averaging flagged with zero count");
`endif
endmodule
`default_nettype wire

// ===== dv/sgd_quantile_regression_averaged_unit_checker.sv =====
`timescale 1ns / 100ps
module sgd_quantile_regression_averaged_unit_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire [2:0]   cfg_index,
  input  wire [24:0]  cfg_data,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire [1:0]   in_operation,
  input  wire [2:0]   in_index,
  input  wire [31:0]  in_load_value,
  input  wire [255:0] in_x,
  input  wire [31:0]  in_response,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire [255:0] out_avg,
  input  wire [23:0]  out_observations_seen,
  input  wire         out_averaging_active,
  output int          pending,
  output int          fail_count
);
  import sqra_pkg::*;

  typedef struct {
    logic signed [31:0] avg [LANES];
    logic [23:0]        seen;
    logic               active;
  } fit_state_t;

  localparam logic [31:0] DECAY_TAB [16] = '{
    32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
    32'd4202935003, 32'd4248701965, 32'd4271771996, 32'd4283353945,
    32'd4289156690, 32'd4292061009, 32'd4293513907, 32'd4294240540,
    32'd4294603903, 32'd4294785595, 32'd4294876445, 32'd4294921870};

  fit_state_t fit_q[$];

  longint coef [LANES];
  longint avg_m [LANES];
  longint mean_m [LANES];
  longint inv_m [LANES];
  logic [23:0] obs_n;
  logic [23:0] burn_r;
  logic [24:0] gamma_r;
  logic [16:0] alpha_r, tau_r;
  logic        std_r;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // log2 in Q16.16 by mantissa squaring
  function automatic longint unsigned log2_fix(input logic [23:0] n);
    int e;
    longint unsigned y, frac;
    e = 0;
    frac = 0;
    while (e < 31 && (32'(n) >> (e + 1)) != 0) e++;
    y = (64'(n) << 30) >> e;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        frac = frac | 1;
      end
    end
    return (64'(e) << 16) | frac;
  endfunction

  // n^-alpha in Q16.16
  function automatic longint unsigned decay_pow(input logic [23:0] n, input logic [16:0] a);
    longint unsigned t, k, m;
    t = (64'(a) * log2_fix(n)) >> 16;
    k = t >> 16;
    m = 64'd1 << 32;
    for (int i = 0; i < 16; i++)
      if ((t >> (15 - i)) & 1) m = (m * 64'(DECAY_TAB[i])) >> 32;
    if (k > 40) return 0;
    return m >> (16 + k);
  endfunction

  task automatic absorb_beat();
    longint z [LANES];
    longint dot, g, lr, s, m, y;
    logic [16:0] a_eff, t_eff;
    fit_state_t f;
    y = longint'($signed(in_response));
    case (sqra_op_t'(in_operation))
      OP_LD_COEF: begin
        coef[in_index] = longint'($signed(in_load_value));
        for (int j = 0; j < LANES; j++) avg_m[j] = 0;
        obs_n = 0;
      end
      OP_LD_MEAN: mean_m[in_index] = longint'($signed(in_load_value));
      OP_LD_INV:  inv_m[in_index] = longint'($signed(in_load_value));
      default: begin
        a_eff = (alpha_r > 17'd65536) ? 17'd65536 : alpha_r;
        t_eff = (tau_r > 17'd65536) ? 17'd65536 : tau_r;
        if (obs_n != CNT_MAX) obs_n = obs_n + 24'd1;
        dot = 0;
        for (int j = 0; j < LANES; j++) begin
          z[j] = longint'($signed(in_x[32*j +: 32]));
          if (std_r) z[j] = clip32((clip32(z[j] - mean_m[j]) * inv_m[j]) >>> 16);
          dot += (z[j] * coef[j]) >>> 16;
        end
        g = (y < dot ? 64'sd65536 : 64'sd0) - longint'(t_eff);
        lr = longint'((64'(gamma_r) * decay_pow(obs_n, a_eff)) >> 16);
        s = clip32((lr * g) >>> 16);
        for (int j = 0; j < LANES; j++) coef[j] = clip32(coef[j] - ((s * z[j]) >>> 16));
        if (obs_n > burn_r) begin
          m = longint'(obs_n - burn_r);
          for (int j = 0; j < LANES; j++) avg_m[j] = clip32((avg_m[j] * (m - 1) + coef[j]) / m);
        end
      end
    endcase
    for (int j = 0; j < LANES; j++) f.avg[j] = avg_m[j][31:0];
    f.seen = obs_n;
    f.active = obs_n > burn_r;
    fit_q.push_back(f);
  endtask

  task automatic match_beat();
    fit_state_t f;
    if (fit_q.size() == 0) begin
      $error("unexpected result beat");
      fail_count++;
      return;
    end
    f = fit_q.pop_front();
    for (int j = 0; j < LANES; j++)
      if (out_avg[32*j +: 32] !== f.avg[j]) begin
        $error("avg_%0d: expected %0d, got %0d", j, f.avg[j], $signed(out_avg[32*j +: 32]));
        fail_count++;
      end
    if (out_observations_seen !== f.seen) begin
      $error("observations_seen: expected %0d, got %0d", f.seen, out_observations_seen);
      fail_count++;
    end
    if (out_averaging_active !== f.active) begin
      $error("averaging_active: expected %0d, got %0d", f.active, out_averaging_active);
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  assign pending = fit_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LANES; j++) begin
        coef[j] = 0; avg_m[j] = 0; mean_m[j] = 0; inv_m[j] = 65536;
      end
      obs_n = 0;
      burn_r = 0; gamma_r = 25'd65536; alpha_r = 17'd32833; tau_r = 17'd32768; std_r = 0;
      fit_q.delete();
    end else begin
      if (out_valid && !out_stall) match_beat();
      if (cfg_valid && cfg_ready) begin
        case (sqra_cfg_idx_t'(cfg_index))
          CFG_BURN:  burn_r = cfg_data[23:0];
          CFG_GAMMA: gamma_r = cfg_data;
          CFG_ALPHA: alpha_r = cfg_data[16:0];
          CFG_TAU:   tau_r = cfg_data[16:0];
          CFG_STD:   std_r = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_beat();
    end
  end

endmodule

// ===== dv/sgd_quantile_regression_averaged_unit_test.sv =====
`timescale 1ns / 100ps
module sgd_quantile_regression_averaged_unit_test;
  import sqra_pkg::*;

  // limit: ~1000 beats with idling at the slowest observation, taken ~5x over
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_BEATS = 190;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [24:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [1:0] in_operation = '0;
  logic [2:0] in_index = '0;
  logic signed [31:0] in_load_value = '0;
  logic signed [31:0] in_x [8];
  logic signed [31:0] in_response = '0;
  logic out_stall = 1'b0;
  wire cfg_ready, in_stall, out_valid, out_averaging_active;
  wire signed [31:0] out_avg [8];
  wire [23:0] out_observations_seen;
  int pending, fail_count;
  int cycles = 0;
  bit calm = 0;       // no idling on either side while set
  int stall_hold = 0; // cycles of receiver stall left before next beat

  initial for (int j = 0; j < 8; j++) in_x[j] = '0;

  always #1 clk = ~clk;

  sgd_quantile_regression_averaged_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_index(in_index), .in_load_value(in_load_value),
    .in_x_0(in_x[0]), .in_x_1(in_x[1]), .in_x_2(in_x[2]), .in_x_3(in_x[3]),
    .in_x_4(in_x[4]), .in_x_5(in_x[5]), .in_x_6(in_x[6]), .in_x_7(in_x[7]),
    .in_response(in_response),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_avg_0(out_avg[0]), .out_avg_1(out_avg[1]), .out_avg_2(out_avg[2]),
    .out_avg_3(out_avg[3]), .out_avg_4(out_avg[4]), .out_avg_5(out_avg[5]),
    .out_avg_6(out_avg[6]), .out_avg_7(out_avg[7]),
    .out_observations_seen(out_observations_seen),
    .out_averaging_active(out_averaging_active)
  );

  sgd_quantile_regression_averaged_unit_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_index(in_index), .in_load_value(in_load_value),
    .in_x({in_x[7], in_x[6], in_x[5], in_x[4], in_x[3], in_x[2], in_x[1], in_x[0]}),
    .in_response(in_response),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_avg({out_avg[7], out_avg[6], out_avg[5], out_avg[4],
              out_avg[3], out_avg[2], out_avg[1], out_avg[0]}),
    .out_observations_seen(out_observations_seen),
    .out_averaging_active(out_averaging_active),
    .pending(pending), .fail_count(fail_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: fresh stall draw after every result beat
  always @(posedge clk)
    if (out_valid && !out_stall) stall_hold <= calm ? 0 : $urandom_range(0, 3);
  always @(negedge clk) begin
    out_stall <= stall_hold > 0;
    if (stall_hold > 0) stall_hold <= stall_hold - 1;
  end

  // Q16.16 value: mostly small magnitudes, some full-range, some rails
  function automatic logic signed [31:0] pick_q();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $signed($urandom_range(0, 524287)) - 32'sd262144;
    if (sel < 8) return $urandom;
    if (sel == 8) return 32'sh7FFFFFFF;
    return 32'sh80000000;
  endfunction

  // stall is sampled mid-cycle so the beat lands on the following rising edge
  task automatic wait_accept();
    bit ok;
    forever begin
      #0.5 ok = !in_stall;
      @(negedge clk);
      if (ok) break;
    end
  endtask

  task automatic send_beat(input sqra_op_t op, input logic [2:0] idx,
                           input logic signed [31:0] lv,
                           input logic signed [31:0] xs [8], input logic signed [31:0] y);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_index <= idx;
    in_load_value <= lv;
    for (int j = 0; j < 8; j++) in_x[j] <= xs[j];
    in_response <= y;
    wait_accept();
  endtask

  task automatic send_obs(input bit rails);
    logic signed [31:0] xs [8];
    for (int j = 0; j < 8; j++) xs[j] = rails ? (j[0] ? 32'sh80000000 : 32'sh7FFFFFFF) : pick_q();
    send_beat(OP_OBS, 3'($urandom_range(0, 7)), $urandom, xs, pick_q());
  endtask

  task automatic send_load(input sqra_op_t op, input logic [2:0] idx, input logic signed [31:0] v);
    logic signed [31:0] xs [8];
    for (int j = 0; j < 8; j++) xs[j] = $urandom;
    send_beat(op, idx, v, xs, $urandom);
  endtask

  // block must be idle: no result outstanding
  task automatic write_reg(input sqra_cfg_idx_t idx, input logic [24:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    forever begin
      #0.5;
      if (cfg_ready) begin
        @(negedge clk);
        break;
      end
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sqra_op_t op;
    int r;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: defaults, rails on loads and features
    send_obs(0);
    send_obs(1);
    for (int k = 1; k < 4; k++) send_load(sqra_op_t'(k), 3'(k * 3), 32'sh7FFFFFFF);
    for (int k = 1; k < 4; k++) send_load(sqra_op_t'(k), 3'(k * 2 + 1), 32'sh80000000);
    send_load(OP_LD_INV, 3'd7, 32'sd65536);
    send_load(OP_LD_MEAN, 3'd0, 32'sd0);
    send_obs(1);
    // burn of one, clamped alpha and tau, gamma of 256.0, standardizing
    write_reg(CFG_BURN, 25'd1);
    write_reg(CFG_ALPHA, 25'd131071);
    write_reg(CFG_TAU, 25'd131071);
    write_reg(CFG_GAMMA, 25'd16777216);
    write_reg(CFG_STD, 25'd1);
    send_load(OP_LD_COEF, 3'd0, 32'sd65536);
    repeat (4) send_obs(0);
    send_obs(1);
    write_reg(CFG_TAU, 25'd0);
    write_reg(CFG_ALPHA, 25'd0);
    repeat (3) send_obs(0);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      calm = (ph == 2);
      case (ph)
        0: begin
          write_reg(CFG_BURN, 25'd0); write_reg(CFG_GAMMA, 25'd0);
          write_reg(CFG_ALPHA, 25'd65536); write_reg(CFG_TAU, 25'd65536);
          write_reg(CFG_STD, 25'd0);
        end
        1: begin
          write_reg(CFG_BURN, 25'd16777215); write_reg(CFG_GAMMA, 25'd65536);
          write_reg(CFG_ALPHA, 25'd32833); write_reg(CFG_STD, 25'd1);
        end
        default: begin
          write_reg(CFG_BURN, 25'($urandom_range(0, 40)));
          write_reg(CFG_GAMMA, 25'($urandom_range(0, 16777216)));
          write_reg(CFG_ALPHA, 25'($urandom_range(0, 131071)));
          write_reg(CFG_TAU, 25'($urandom_range(0, 131071)));
          write_reg(CFG_STD, 25'($urandom_range(0, 1)));
        end
      endcase
      for (int k = 0; k < PHASE_BEATS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 84) send_obs(r == 0);
        else begin
          op = (r < 88) ? OP_LD_COEF : (r < 94) ? OP_LD_MEAN : OP_LD_INV;
          send_load(op, 3'($urandom_range(0, 7)),
                    (op == OP_LD_INV && r[0]) ? $signed($urandom_range(0, 131072)) : pick_q());
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (700) @(negedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
